// ===== rtl/minmax_polyline_decimator_core_macros.svh =====
// Assertion macros shared by the decimator core.
`ifndef MINMAX_POLYLINE_DECIMATOR_CORE_MACROS_SVH
`define MINMAX_POLYLINE_DECIMATOR_CORE_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define MMPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define MMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mmpd_pkg.sv =====
// Types, constants and command structures of the min/max polyline decimator.
package mmpd_pkg;

    localparam int MAX_BUCKETS  = 31;
    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int BKT_W        = 5;
    localparam int DIV_STEPS    = 8;
    localparam int CNT_DIV_W    = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_MODE    = 1'b1;

    localparam logic [BKT_W-1:0] BUCKET_COUNT_RST = 5'd16;

    typedef struct packed {
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic               end_of_strip;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               last_of_run;
        logic               truncated;
    } t_out;

    typedef enum logic [1:0] {
        RD_ZERO  = 2'd0,
        RD_LASTV = 2'd1,
        RD_IDX   = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        SRC_FIRST = 3'd0,
        SRC_LAST  = 3'd1,
        SRC_RAW   = 3'd2,
        SRC_BLO   = 3'd3,
        SRC_BHI   = 3'd4
    } t_src;

    typedef struct packed {
        logic    load;
        logic    fin_init;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_first;
        logic    cap_span;
        logic    mul;
        logic    upd;
        logic    idx_inc;
        logic    push;
        t_src    src;
        logic    bkt_inc;
        logic    flush;
    } t_cmd;

    typedef struct packed {
        logic pass_thru;
        logic idx_last;
        logic bkt_last;
        logic div_done;
    } t_stat;

endpackage

// ===== rtl/minmax_polyline_decimator_core.sv =====
// Top level of the min/max bucket polyline decimator.
// Loading stores one vertex per request; a request without end of strip leaves busy low.
// At end of strip the first and last vertices are read; up to 2B+2 vertices pass unchanged,
// else each is bucketed, with no divide if its numerator is negative, and the buckets emitted.
// Results come one per cycle at most and cannot be stalled; the last follows busy falling.
// Reset (synchronous, active low) empties the store, B = 16 and integer time mode.
module minmax_polyline_decimator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mmpd_pkg::t_in                   i_in,
    output logic                            o_result_valid,
    output mmpd_pkg::t_out                  o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mmpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mmpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mmpd_pkg::*;

`include "minmax_polyline_decimator_core_macros.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    // Always taken; the user must write configuration only while the core is idle (not enforced).
    assign o_cfg_ready = 1'b1;

    // The controller sequences the whole strip; the datapath holds all data storage.
    mmpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_eos   (i_in.end_of_strip),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    mmpd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_stat         (w_stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // A request closing a strip always starts the finishing sequence.
    `MMPD_ASSERT_NEXT(a_eos_busy, start && !busy && i_in.end_of_strip, busy, "strip end not taken")
    // The final result of a strip appears only once the core has gone idle.
    `MMPD_ASSERT_NOW(a_last_idle, o_result_valid && o_result.last_of_run, !busy, "last while busy")
    // Every other result appears while the strip is still being finished.
    `MMPD_ASSERT_NOW(a_mid_busy, o_result_valid && !o_result.last_of_run, busy, "result when idle")

endmodule

// ===== rtl/mmpd_div.sv =====
// Restoring divider, one quotient bit per cycle, giving a saturating bucket quotient.
module mmpd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic signed [38:0]           i_num,
    input  logic        [32:0]           i_den,
    output logic                         o_done,
    output logic [mmpd_pkg::DIV_STEPS-1:0] o_quot
);
    import mmpd_pkg::*;

    logic [CNT_DIV_W-1:0] r_cnt;
    logic [37:0]          r_rem;
    logic [39:0]          r_dsh;
    logic [DIV_STEPS-1:0] r_q;
    logic                 w_ge;

    assign w_ge   = {2'b00, r_rem} >= r_dsh;
    assign o_done = (r_cnt == '0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            // A negative numerator floors below zero and clamps to bucket zero at once.
            r_cnt <= i_num[38] ? '0 : CNT_DIV_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_num[37:0];
            r_dsh <= {i_den, 7'b0};
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh[37:0];
            end
            r_q   <= {r_q[DIV_STEPS-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

endmodule

// ===== rtl/mmpd_dp.sv =====
// Datapath: vertex store, span and bucket arithmetic, bucket extrema and emission.
module mmpd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mmpd_pkg::t_in                     i_in,
    input  mmpd_pkg::t_cmd                    i_cmd,
    input  logic                              i_cfg_we,
    input  logic [mmpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mmpd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mmpd_pkg::t_stat                   o_stat,
    output logic                              o_result_valid,
    output mmpd_pkg::t_out                    o_result
);
    import mmpd_pkg::*;

    logic [63:0]        r_mem [MAX_VERTICES];
    logic [63:0]        r_rd_data;
    logic [ADDR_W-1:0]  w_rd_addr;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic               r_ovf;
    logic [BKT_W-1:0]   r_bucket_count;
    logic               r_time_mode;
    logic [BKT_W-1:0]   r_nb;
    logic               r_mode;

    logic signed [31:0] r_first_x, r_first_y, r_last_x, r_last_y;
    logic signed [31:0] r_vx, r_vy;
    logic               r_byidx, r_neg;
    logic [32:0]        r_den;
    logic [ADDR_W-1:0]  r_idx;
    logic [BKT_W-1:0]   r_bkt;

    logic [MAX_BUCKETS-1:0] r_seen;
    logic signed [31:0] r_min_x [MAX_BUCKETS];
    logic signed [31:0] r_min_y [MAX_BUCKETS];
    logic signed [31:0] r_max_x [MAX_BUCKETS];
    logic signed [31:0] r_max_y [MAX_BUCKETS];

    logic               r_le_v;
    logic signed [31:0] r_le_x, r_le_y;
    logic [1:0]         r_nout;
    logic               r_pend_v;
    logic signed [31:0] r_pend_x, r_pend_y;
    logic               r_out_v;
    t_out               r_out;

    logic signed [31:0] w_rx, w_ry;
    logic signed [32:0] w_span, w_diff;
    logic signed [38:0] w_prod, w_num;
    logic [16:0]        w_iprod;
    logic               w_div_done;
    logic [DIV_STEPS-1:0] w_quot;
    logic [BKT_W-1:0]   w_qb, w_b;
    logic [CNT_W-1:0]   w_pass_lim;

    logic signed [31:0] w_bx1, w_by1, w_bx2, w_by2;
    logic               w_same, w_ord;
    logic signed [31:0] w_cx, w_cy;
    logic               w_c_ok, w_c_dd, w_c_force, w_push_ok;
    logic               w_min_upd, w_max_upd;

    assign w_rx     = r_rd_data[63:32];
    assign w_ry     = r_rd_data[31:0];
    assign w_cnt_m1 = r_count - 1'b1;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_ZERO:  w_rd_addr = '0;
            RD_LASTV: w_rd_addr = w_cnt_m1[ADDR_W-1:0];
            RD_IDX:   w_rd_addr = r_idx;
            default:  w_rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !r_count[CNT_W-1]) begin
            r_mem[r_count[ADDR_W-1:0]] <= {i_in.sample_x, i_in.sample_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Span of the strip, exact in 33 bits.
    assign w_span = $signed({w_rx[31], w_rx}) - $signed({r_first_x[31], r_first_x});

    // Bucket numerator; a negative span is folded into the numerator's sign.
    assign w_diff  = r_neg ? ($signed({r_first_x[31], r_first_x}) - $signed({w_rx[31], w_rx}))
                           : ($signed({w_rx[31], w_rx}) - $signed({r_first_x[31], r_first_x}));
    assign w_prod  = 39'(w_diff) * 39'($signed({1'b0, r_nb}));
    assign w_iprod = 17'(r_idx) * 17'(r_nb);
    assign w_num   = r_byidx ? $signed(39'(w_iprod)) : w_prod;

    mmpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cmd.mul),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_qb = (w_quot >= DIV_STEPS'(r_nb)) ? (r_nb - 1'b1) : w_quot[BKT_W-1:0];
    assign w_b  = i_cmd.upd ? w_qb : r_bkt;

    assign w_bx1  = r_min_x[w_b];
    assign w_by1  = r_min_y[w_b];
    assign w_bx2  = r_max_x[w_b];
    assign w_by2  = r_max_y[w_b];
    assign w_same = (w_bx1 == w_bx2) && (w_by1 == w_by2);
    assign w_ord  = (w_bx1 < w_bx2) || ((w_bx1 == w_bx2) && (w_by1 <= w_by2));

    assign w_min_upd = (r_vy < w_by1) || ((r_vy == w_by1) && (r_vx < w_bx1));
    assign w_max_upd = (r_vy > w_by2) || ((r_vy == w_by2) && (r_vx < w_bx2));

    always_comb begin
        w_cx      = r_first_x;
        w_cy      = r_first_y;
        w_c_ok    = 1'b1;
        w_c_dd    = 1'b1;
        w_c_force = 1'b0;
        case (i_cmd.src)
            SRC_FIRST: begin
                w_cx = r_first_x;
                w_cy = r_first_y;
            end
            SRC_LAST: begin
                w_cx      = r_last_x;
                w_cy      = r_last_y;
                // Everything collapsed onto the first vertex: the last one goes out anyway.
                w_c_force = (r_nout == 2'd1);
            end
            SRC_RAW: begin
                w_cx   = w_rx;
                w_cy   = w_ry;
                w_c_dd = 1'b0;
            end
            SRC_BLO: begin
                w_cx   = w_ord ? w_bx1 : w_bx2;
                w_cy   = w_ord ? w_by1 : w_by2;
                w_c_ok = r_seen[w_b];
            end
            SRC_BHI: begin
                w_cx   = w_ord ? w_bx2 : w_bx1;
                w_cy   = w_ord ? w_by2 : w_by1;
                w_c_ok = r_seen[w_b] && !w_same;
            end
            default: begin
                w_c_ok = 1'b0;
            end
        endcase
    end

    assign w_push_ok = i_cmd.push && w_c_ok
                       && (!w_c_dd || w_c_force || !r_le_v || (w_cx != r_le_x) || (w_cy != r_le_y));

    assign w_pass_lim       = CNT_W'({r_nb, 1'b0}) + CNT_W'(2);
    assign o_stat.pass_thru = (r_count < CNT_W'(2)) || (r_count <= w_pass_lim);
    assign o_stat.idx_last  = ({1'b0, r_idx} == w_cnt_m1);
    assign o_stat.bkt_last  = (r_bkt == (r_nb - 1'b1));
    assign o_stat.div_done  = w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_ovf          <= 1'b0;
            r_bucket_count <= BUCKET_COUNT_RST;
            r_time_mode    <= 1'b1;
            r_seen         <= '0;
            r_le_v         <= 1'b0;
            r_nout         <= '0;
            r_pend_v       <= 1'b0;
            r_out_v        <= 1'b0;
            r_idx          <= '0;
            r_bkt          <= '0;
        end else begin
            r_out_v <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BUCKET_COUNT: r_bucket_count <= i_cfg_data[BKT_W-1:0];
                    REG_TIME_MODE:    r_time_mode    <= i_cfg_data[0];
                endcase
            end
            if (i_cmd.load) begin
                if (!r_count[CNT_W-1]) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.fin_init) begin
                r_seen   <= '0;
                r_le_v   <= 1'b0;
                r_nout   <= '0;
                r_pend_v <= 1'b0;
                r_idx    <= '0;
                r_bkt    <= '0;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.bkt_inc) begin
                r_bkt <= r_bkt + 1'b1;
            end
            if (i_cmd.upd) begin
                r_seen[w_b] <= 1'b1;
            end
            if (w_push_ok) begin
                r_le_v   <= 1'b1;
                r_pend_v <= 1'b1;
                if (r_nout != 2'd2) begin
                    r_nout <= r_nout + 1'b1;
                end
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end
            end
            if (i_cmd.flush) begin
                r_out_v  <= r_pend_v;
                r_pend_v <= 1'b0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_in.end_of_strip) begin
            r_nb   <= (r_bucket_count == '0) ? BKT_W'(1) : r_bucket_count;
            r_mode <= r_time_mode;
        end
        if (i_cmd.cap_first) begin
            r_first_x <= w_rx;
            r_first_y <= w_ry;
        end
        if (i_cmd.cap_span) begin
            r_last_x <= w_rx;
            r_last_y <= w_ry;
            r_byidx  <= r_mode ? (w_span <= 0) : (w_span == 0);
            r_neg    <= w_span < 0;
            if (r_mode ? (w_span <= 0) : (w_span == 0)) begin
                r_den <= 33'(r_count);
            end else begin
                r_den <= (w_span < 0) ? 33'(-w_span) : 33'(w_span);
            end
        end
        if (i_cmd.mul) begin
            r_vx <= w_rx;
            r_vy <= w_ry;
        end
        if (i_cmd.upd) begin
            if (!r_seen[w_b] || w_min_upd) begin
                r_min_x[w_b] <= r_vx;
                r_min_y[w_b] <= r_vy;
            end
            if (!r_seen[w_b] || w_max_upd) begin
                r_max_x[w_b] <= r_vx;
                r_max_y[w_b] <= r_vy;
            end
        end
        if (w_push_ok) begin
            r_le_x   <= w_cx;
            r_le_y   <= w_cy;
            r_pend_x <= w_cx;
            r_pend_y <= w_cy;
            r_out    <= '{out_x: r_pend_x, out_y: r_pend_y, last_of_run: 1'b0,
                          truncated: r_ovf};
        end
        if (i_cmd.flush) begin
            r_out <= '{out_x: r_pend_x, out_y: r_pend_y, last_of_run: 1'b1,
                       truncated: r_ovf};
        end
    end

    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

endmodule

// ===== rtl/mmpd_ctrl.sv =====
// Controller state machine sequencing load, bucketing and emission.
module mmpd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_eos,
    input  mmpd_pkg::t_stat i_stat,
    output mmpd_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import mmpd_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_FIRST   = 15'b000000000000010,
        S_LASTR   = 15'b000000000000100,
        S_SPAN    = 15'b000000000001000,
        S_RAW_RD  = 15'b000000000010000,
        S_RAW_PUT = 15'b000000000100000,
        S_V_RD    = 15'b000000001000000,
        S_V_MUL   = 15'b000000010000000,
        S_V_DIV   = 15'b000000100000000,
        S_V_UPD   = 15'b000001000000000,
        S_E_FIRST = 15'b000010000000000,
        S_E_B1    = 15'b000100000000000,
        S_E_B2    = 15'b001000000000000,
        S_E_LAST  = 15'b010000000000000,
        S_FLUSH   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_ZERO;
        o_cmd.src    = SRC_FIRST;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start && i_eos) begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                o_cmd.fin_init = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_ZERO;
                n_state        = S_LASTR;
            end
            S_LASTR: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = RD_LASTV;
                n_state         = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.cap_span = 1'b1;
                n_state        = i_stat.pass_thru ? S_RAW_RD : S_V_RD;
            end
            S_RAW_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_RAW_PUT;
            end
            S_RAW_PUT: begin
                o_cmd.push    = 1'b1;
                o_cmd.src     = SRC_RAW;
                o_cmd.idx_inc = 1'b1;
                n_state       = i_stat.idx_last ? S_FLUSH : S_RAW_RD;
            end
            S_V_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_V_MUL;
            end
            S_V_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_V_DIV;
            end
            S_V_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_V_UPD;
                end
            end
            S_V_UPD: begin
                o_cmd.upd     = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = i_stat.idx_last ? S_E_FIRST : S_V_RD;
            end
            S_E_FIRST: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_FIRST;
                n_state    = S_E_B1;
            end
            S_E_B1: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_BLO;
                n_state    = S_E_B2;
            end
            S_E_B2: begin
                o_cmd.push    = 1'b1;
                o_cmd.src     = SRC_BHI;
                o_cmd.bkt_inc = 1'b1;
                n_state       = i_stat.bkt_last ? S_E_LAST : S_E_B1;
            end
            S_E_LAST: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_LAST;
                n_state    = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the min/max bucket polyline decimator core.
`timescale 1ns / 100ps

module testbench;
    import mmpd_pkg::*;

    localparam int  HALF_PERIOD   = 10;
    localparam int  RESET_CYCLES  = 6;
    localparam int  DRAIN_CYCLES  = 64;
    localparam int  RANDOM_ITEMS  = 420;
    localparam int  CYCLE_LIMIT   = 3000000;
    localparam int  OUT_LIMIT     = 64;
    localparam bit  MODE_REAL     = 1'b0;
    localparam bit  MODE_TIME     = 1'b1;

    // Shapes of the x sequence of a generated strip.
    localparam int  SHAPE_RAMP    = 0;
    localparam int  SHAPE_FALL    = 1;
    localparam int  SHAPE_FLAT    = 2;
    localparam int  SHAPE_NOISE   = 3;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 eos;
        bit                 typed;
        t_out               want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in                   i_in;
    logic                  o_result_valid;
    t_out                  o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    minmax_polyline_decimator_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in           (i_in),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Shadow copy of the block's state, kept by the predictor.
    logic signed [31:0] strip_x [MAX_VERTICES];
    logic signed [31:0] strip_y [MAX_VERTICES];
    int                 strip_len;
    bit                 strip_overflow;
    logic [4:0]         shadow_buckets;
    bit                 shadow_mode;

    bit                 prev_valid;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;

    t_out               pending_points[$];
    t_out               strip_points[$];
    int                 mismatches;
    longint             cycle_count;
    int                 items_sent;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Run guard: a hung block must not keep the simulation going for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Every strobed result is matched against the oldest predicted vertex. The
    // receiver cannot push back, so the check happens on the strobe alone.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", o_result.out_x, o_result.out_y);
                mismatches++;
            end else begin
                t_out want;
                want = pending_points.pop_front();
                if (o_result.out_x !== want.out_x) begin
                    $error("out_x expected %0d actual %0d", want.out_x, o_result.out_x);
                    mismatches++;
                end
                if (o_result.out_y !== want.out_y) begin
                    $error("out_y expected %0d actual %0d", want.out_y, o_result.out_y);
                    mismatches++;
                end
                if (o_result.last_of_run !== want.last_of_run) begin
                    $error("last_of_run expected %0b actual %0b",
                           want.last_of_run, o_result.last_of_run);
                    mismatches++;
                end
                if (o_result.truncated !== want.truncated) begin
                    $error("truncated expected %0b actual %0b",
                           want.truncated, o_result.truncated);
                    mismatches++;
                end
            end
        end
    end

    // Adds one vertex to the strip's output list unless it already holds OUT_LIMIT; with
    // skip_repeat set, a vertex equal to the one emitted just before it is dropped.
    function automatic void emit_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                        bit skip_repeat);
        t_out p;
        if (skip_repeat && prev_valid && prev_x == x && prev_y == y)
            return;
        if (strip_points.size() >= OUT_LIMIT)
            return;
        p.out_x       = x;
        p.out_y       = y;
        p.last_of_run = 1'b0;
        p.truncated   = strip_overflow;
        strip_points.insert(strip_points.size(), p);
        prev_valid = 1'b1;
        prev_x     = x;
        prev_y     = y;
    endfunction

    // Decimates the stored strip and queues the vertices the block should emit.
    function automatic void decimate_strip();
        int                 count;
        int                 nb;
        longint             first_x;
        longint             span;
        longint             num;
        longint             bkt;
        bit                 by_index;
        bit                 seen   [MAX_BUCKETS];
        logic signed [31:0] lo_x   [MAX_BUCKETS];
        logic signed [31:0] lo_y   [MAX_BUCKETS];
        logic signed [31:0] hi_x   [MAX_BUCKETS];
        logic signed [31:0] hi_y   [MAX_BUCKETS];
        logic signed [31:0] x;
        logic signed [31:0] y;
        count = strip_len;
        nb    = (shadow_buckets == 0) ? 1 : int'(shadow_buckets);
        if (nb > MAX_BUCKETS)
            nb = MAX_BUCKETS;
        prev_valid = 1'b0;
        strip_points.delete();
        for (int b = 0; b < MAX_BUCKETS; b++)
            seen[b] = 1'b0;

        if (count < 2 || count <= 2 * nb + 2) begin
            for (int i = 0; i < count; i++)
                emit_vertex(strip_x[i], strip_y[i], 1'b0);
        end else begin
            first_x  = strip_x[0];
            span     = longint'(strip_x[count-1]) - first_x;
            by_index = (shadow_mode == MODE_TIME) ? (span <= 0) : (span == 0);
            for (int i = 0; i < count; i++) begin
                x = strip_x[i];
                y = strip_y[i];
                if (by_index) begin
                    bkt = (longint'(i) * nb) / count;
                end else begin
                    // Floor division: the language truncates towards zero.
                    num = (longint'(x) - first_x) * nb;
                    bkt = num / span;
                    if ((num % span) != 0 && ((num < 0) != (span < 0)))
                        bkt--;
                    if (bkt < 0)
                        bkt = 0;
                end
                if (bkt >= nb)
                    bkt = nb - 1;
                if (!seen[bkt]) begin
                    seen[bkt] = 1'b1;
                    lo_x[bkt] = x; lo_y[bkt] = y;
                    hi_x[bkt] = x; hi_y[bkt] = y;
                end else begin
                    if (y < lo_y[bkt] || (y == lo_y[bkt] && x < lo_x[bkt])) begin
                        lo_x[bkt] = x; lo_y[bkt] = y;
                    end
                    if (y > hi_y[bkt] || (y == hi_y[bkt] && x < hi_x[bkt])) begin
                        hi_x[bkt] = x; hi_y[bkt] = y;
                    end
                end
            end
            emit_vertex(strip_x[0], strip_y[0], 1'b1);
            for (int b = 0; b < nb; b++) begin
                if (!seen[b])
                    continue;
                if (lo_x[b] == hi_x[b] && lo_y[b] == hi_y[b]) begin
                    emit_vertex(lo_x[b], lo_y[b], 1'b1);
                end else if (lo_x[b] < hi_x[b] || (lo_x[b] == hi_x[b] && lo_y[b] <= hi_y[b]))
                begin
                    emit_vertex(lo_x[b], lo_y[b], 1'b1);
                    emit_vertex(hi_x[b], hi_y[b], 1'b1);
                end else begin
                    emit_vertex(hi_x[b], hi_y[b], 1'b1);
                    emit_vertex(lo_x[b], lo_y[b], 1'b1);
                end
            end
            emit_vertex(strip_x[count-1], strip_y[count-1], 1'b1);
            // An identical strip collapses to one point: first and last go out as they are.
            if (strip_points.size() < 2) begin
                strip_points.delete();
                emit_vertex(strip_x[0], strip_y[0], 1'b0);
                emit_vertex(strip_x[count-1], strip_y[count-1], 1'b0);
            end
        end
        if (strip_points.size() > 0)
            strip_points[strip_points.size()-1].last_of_run = 1'b1;
        strip_len      = 0;
        strip_overflow = 1'b0;
        prev_valid     = 1'b0;
    endfunction

    // Updates the shadow state with one accepted request.
    function automatic void predict_vertex(t_in req);
        if (strip_len < MAX_VERTICES) begin
            strip_x[strip_len] = req.sample_x;
            strip_y[strip_len] = req.sample_y;
            strip_len++;
        end else begin
            strip_overflow = 1'b1;
        end
        if (req.end_of_strip)
            decimate_strip();
        else
            strip_points.delete();
    endfunction

    // Random gap before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one request, holds it until the block takes it, then predicts.
    // When typed is set the listed result replaces the predicted one.
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, bit eos,
                               bit typed, t_out want, bit allow_gap);
        int gap;
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start            <= 1'b1;
        i_in.sample_x     <= x;
        i_in.sample_y     <= y;
        i_in.end_of_strip <= eos;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_vertex(t_in'{sample_x: x, sample_y: y, end_of_strip: eos});
        if (typed)
            pending_points.insert(pending_points.size(), want);
        else
            foreach (strip_points[k])
                pending_points.insert(pending_points.size(), strip_points[k]);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Waits for all predicted results and for the block to settle, then writes.
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (index == REG_BUCKET_COUNT)
            shadow_buckets = data;
        else
            shadow_mode = data[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one generated strip of the given length and x shape.
    task automatic send_strip(int len, int shape);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] y_pool[4];
        t_out               none;
        none = '0;
        x = (shape == SHAPE_NOISE) ? $urandom : $signed($urandom_range(0, 1 << 21)) - 1048576;
        foreach (y_pool[k])
            y_pool[k] = $urandom;
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_RAMP:  x = x + $urandom_range(0, 5);
                SHAPE_FALL:  x = x - $urandom_range(0, 5);
                SHAPE_FLAT:  x = x;
                default:     x = (i == 0) ? x : $urandom;
            endcase
            // A small pool of repeated y values makes ties common.
            if ($urandom_range(0, 2) == 0)
                y = y_pool[$urandom_range(0, 3)];
            else
                y = $urandom;
            send_vertex(x, y, i == len - 1, 1'b0, none, 1'b1);
        end
    endtask

    initial begin
        t_row rows[10];
        t_out none;
        int   nb;
        int   len;
        int   strips;

        none = '0;
        // Single-vertex strips pass unchanged, so their results are typed in;
        // the multi-vertex rows go through the predictor.
        rows = '{
            '{32'sh7fffffff, 32'sh80000000, 1'b1, 1'b1,
              '{32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0}},
            '{32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1,
              '{32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0}},
            '{32'sh00000000, 32'sh00000000, 1'b1, 1'b1,
              '{32'sh00000000, 32'sh00000000, 1'b1, 1'b0}},
            '{32'shffffffff, 32'shffffffff, 1'b1, 1'b1,
              '{32'shffffffff, 32'shffffffff, 1'b1, 1'b0}},
            '{32'sh00000005, 32'sh00010000, 1'b0, 1'b0, '0},
            '{32'sh00000006, -32'sh00010000, 1'b1, 1'b0, '0},
            '{32'sh55555555, 32'shaaaaaaaa, 1'b0, 1'b0, '0},
            '{32'shaaaaaaaa, 32'sh55555555, 1'b0, 1'b0, '0},
            '{32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b0, '0},
            '{32'sh00001234, 32'sh00005678, 1'b1, 1'b1,
              '{32'sh00001234, 32'sh00005678, 1'b1, 1'b0}}
        };

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_in           = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        mismatches     = 0;
        cycle_count    = 0;
        items_sent     = 0;
        strip_len      = 0;
        strip_overflow = 1'b0;
        prev_valid     = 1'b0;
        shadow_buckets = BUCKET_COUNT_RST;
        shadow_mode    = MODE_TIME;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part, under the reset configuration.
        foreach (rows[r])
            send_vertex(rows[r].x, rows[r].y, rows[r].eos, rows[r].typed, rows[r].want, 1'b0);

        // Identical strip longer than 2B+2: collapses to first and last.
        for (int i = 0; i < 40; i++)
            send_vertex(32'sd77, 32'sd99, i == 39, 1'b0, none, 1'b0);
        // Falling time with more than 2B+2 vertices: the index rule applies.
        send_strip(45, SHAPE_FALL);

        // Real mode with the extreme bucket counts and a span of either sign.
        write_register(REG_TIME_MODE, CFG_DATA_W'(MODE_REAL));
        write_register(REG_BUCKET_COUNT, 5'd1);
        send_strip(12, SHAPE_FALL);
        send_strip(12, SHAPE_FLAT);
        write_register(REG_BUCKET_COUNT, 5'd31);
        send_strip(70, SHAPE_RAMP);
        send_strip(70, SHAPE_NOISE);
        // A zero bucket count behaves as one bucket.
        write_register(REG_BUCKET_COUNT, 5'd0);
        send_strip(9, SHAPE_RAMP);

        // Random part: a fresh configuration every few strips, and strips that
        // are mostly just above the pass-through length so buckets do work.
        strips = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (strips % 4 == 0) begin
                write_register(REG_BUCKET_COUNT, 5'($urandom_range(0, MAX_BUCKETS)));
                write_register(REG_TIME_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            end
            nb  = (shadow_buckets == 0) ? 1 : int'(shadow_buckets);
            if ($urandom_range(0, 9) < 7)
                len = $urandom_range(2 * nb + 3, 2 * nb + 3 + $urandom_range(0, 30));
            else
                len = $urandom_range(1, 2 * nb + 2);
            send_strip(len, $urandom_range(SHAPE_RAMP, SHAPE_NOISE));
            strips++;
        end

        // One strip beyond the store: the end vertex is dropped with the rest.
        write_register(REG_BUCKET_COUNT, 5'd31);
        write_register(REG_TIME_MODE, CFG_DATA_W'(MODE_TIME));
        for (int i = 0; i < MAX_VERTICES + 3; i++)
            send_vertex(32'(i * 3), $urandom, i == MAX_VERTICES + 2, 1'b0, none, 1'b0);

        start <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
